FILE: hdl/bpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the buddy page allocator.
// No dependencies; the top level imports this package.
package bpa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PG_W       = $clog2(MAX_PAGES);
    localparam int LINK_W     = PG_W + 1;
    localparam int TOP_ORDER  = 10;
    localparam int ORD_W      = 4;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 23;
    localparam int FC_W       = 11;
    localparam int LISTS      = TOP_ORDER + 1;
    localparam int LIST_W     = $clog2(LISTS);

    localparam logic [LINK_W-1:0] NIL        = LINK_W'(MAX_PAGES);
    localparam logic [LINK_W-1:0] GRP        = LINK_W'(1 << TOP_ORDER);
    localparam logic [ORD_W-1:0]  ORDER_NONE = '1;
    localparam logic [ORD_W-1:0]  ORDER_TOP  = ORD_W'(TOP_ORDER);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_BUILD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_BLOCK  = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic {
        CFG_BASE_ADDRESS = 1'b0,
        CFG_FRAME_COUNT  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        cmd_t               command;
        logic [SIZE_W-1:0]  size_bytes;
        logic [ADDR_W-1:0]  address;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  block_address;
        logic [ORD_W-1:0]   block_order;
    } out_t;

    // One entry per page frame.
    typedef struct packed {
        logic               reserved;
        logic [ORD_W-1:0]   order;
    } page_t;

    typedef struct packed {
        logic [LINK_W-1:0]  next;
        logic [LINK_W-1:0]  prev;
    } link_t;

    // Smallest order whose block covers the given page count.
    function automatic logic [ORD_W-1:0] order_for(input logic [SIZE_W-PAGE_SHIFT:0] pages);
        logic [SIZE_W-PAGE_SHIFT:0] m;
        logic [ORD_W-1:0]           t;
        m = pages - 1'b1;
        t = '0;
        if (pages > 1) begin
            for (int i = 0; i <= SIZE_W - PAGE_SHIFT; i++) begin
                if (m[i]) t = ORD_W'(i + 1);
            end
        end
        return t;
    endfunction

endpackage

FILE: hdl/bpa_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with a registered read port.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/buddy_page_allocator_top.sv
`timescale 1ns / 1ps
// Buddy page allocator top level: sequencer, list heads and tails, and result register.
// Depends on bpa_pkg and bpa_ram.
//
// The frame table lives in two RAMs with registered reads: one holds the reserved bit and
// order of every page, the other the next/prev free-list links. After reset the block
// runs a clearing pass over every entry of the page RAM, during which no command is
// taken (configuration writes still are). Commands are handled one at a time by a
// sequencer that splits each RAM read-modify-write into a read state and a write state.
// An allocate unlinks the lowest fitting block and pushes each split-off half; a free
// merges with free buddies before its push; a reserve marks each page in range; a build
// pushes each group without a reserved page to the top-order list. A rejected command
// skips to the result. The next command is taken while a finished result still waits on the output.
module buddy_page_allocator_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bpa_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bpa_pkg::out_t                m_data,
    input  logic                         cfg_we,
    input  bpa_pkg::cfg_index_t          cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]   cfg_data
);
    import bpa_pkg::*;

    localparam int NST = 29;

    typedef enum logic [NST-1:0] {
        S_CLR       = NST'(1) << 0,
        S_IDLE      = NST'(1) << 1,
        S_ALC       = NST'(1) << 2,
        S_SPLIT     = NST'(1) << 3,
        S_SPL_WR    = NST'(1) << 4,
        S_FREE_A    = NST'(1) << 5,
        S_FREE_B    = NST'(1) << 6,
        S_FREE_ORD  = NST'(1) << 7,
        S_MRG_TEST  = NST'(1) << 8,
        S_MRG_CHK   = NST'(1) << 9,
        S_MRG_UPD   = NST'(1) << 10,
        S_FREE_PUSH = NST'(1) << 11,
        S_RSV_A     = NST'(1) << 12,
        S_RSV_B     = NST'(1) << 13,
        S_RSV_RD    = NST'(1) << 14,
        S_RSV_WR    = NST'(1) << 15,
        S_BLD_START = NST'(1) << 16,
        S_BLD_RD    = NST'(1) << 17,
        S_BLD_CHK   = NST'(1) << 18,
        S_BLD_PUSH  = NST'(1) << 19,
        S_BLD_NEXT  = NST'(1) << 20,
        S_UNL_RD    = NST'(1) << 21,
        S_UNL_DAT   = NST'(1) << 22,
        S_UNL_N     = NST'(1) << 23,
        S_PUSH_H    = NST'(1) << 24,
        S_PUSH_T    = NST'(1) << 25,
        S_PATCH_RD  = NST'(1) << 26,
        S_PATCH_WR  = NST'(1) << 27,
        S_FIN       = NST'(1) << 28
    } state_t;

    localparam int PGN_W = ADDR_W - PAGE_SHIFT;

    // Memory ports.
    logic              page_we, link_we;
    logic [PG_W-1:0]   page_waddr, page_raddr, link_waddr, link_raddr;
    page_t             page_wdata, page_q;
    link_t             link_wdata, link_q;

    bpa_ram #(.WIDTH($bits(page_t)), .DEPTH(MAX_PAGES)) u_page_ram (
        .aclk(aclk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
        .raddr(page_raddr), .rdata(page_q)
    );

    bpa_ram #(.WIDTH($bits(link_t)), .DEPTH(MAX_PAGES)) u_link_ram (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_q)
    );

    state_t              state_reg, state_next;
    state_t              call_ret_reg, call_ret_next;
    state_t              patch_ret_reg, patch_ret_next;
    logic [PG_W-1:0]     clr_reg, clr_next;
    in_t                 cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [FC_W-1:0]     fcnt_reg, fcnt_next;
    logic [LINK_W-1:0]   head_reg [LISTS];
    logic [LINK_W-1:0]   head_next [LISTS];
    logic [LINK_W-1:0]   tail_reg [LISTS];
    logic [LINK_W-1:0]   tail_next [LISTS];
    logic [PG_W-1:0]     idx_reg, idx_next;
    logic [PG_W-1:0]     bud_reg, bud_next;
    logic [ORD_W-1:0]    cur_reg, cur_next;
    logic [ORD_W-1:0]    tgt_reg, tgt_next;
    logic [LINK_W-1:0]   node_reg, node_next;
    logic [LIST_W-1:0]   lst_reg, lst_next;
    logic [LINK_W-1:0]   pl_reg, pl_next;
    logic [LINK_W-1:0]   nl_reg, nl_next;
    logic [LINK_W-1:0]   patch_addr_reg, patch_addr_next;
    logic                patch_nxt_reg, patch_nxt_next;
    logic [LINK_W-1:0]   patch_val_reg, patch_val_next;
    logic [ADDR_W:0]     wide_reg, wide_next;
    logic [PGN_W-1:0]    lo_reg, lo_next;
    logic [PG_W-1:0]     hi_reg, hi_next;
    logic [PG_W-1:0]     rp_reg, rp_next;
    logic [LINK_W-1:0]   bi_reg, bi_next;
    logic [LINK_W-1:0]   bj_reg, bj_next;
    out_t                res_reg, res_next;
    out_t                out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic [FC_W-1:0]     fc_eff;
    logic [LINK_W-1:0]   fc_link;
    logic [SIZE_W-PAGE_SHIFT:0] pages;
    logic [ORD_W-1:0]    target;
    logic                found;
    logic [ORD_W-1:0]    found_ord;
    logic [LINK_W-1:0]   bsum;
    logic [PG_W-1:0]     bx;
    logic [ADDR_W:0]     hi_off;
    logic [PGN_W:0]      hi_pg;
    logic [LINK_W-1:0]   bj_inc;
    logic [ORD_W-1:0]    cur_dec;

    assign fc_eff  = (fcnt_reg > FC_W'(MAX_PAGES)) ? FC_W'(MAX_PAGES) : fcnt_reg;
    assign fc_link = LINK_W'(fc_eff);
    assign pages   = (SIZE_W-PAGE_SHIFT+1)'(({1'b0, cmd_reg.size_bytes}
                     + (SIZE_W+1)'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT);
    assign target  = order_for(pages);
    assign cur_dec = cur_reg - 1'b1;
    assign bsum    = {1'b0, idx_reg} + (LINK_W'(1) << cur_dec);
    assign bx      = idx_reg ^ (PG_W'(1) << cur_reg);
    assign hi_off  = wide_reg - {1'b0, base_reg};
    assign hi_pg   = hi_off[ADDR_W:PAGE_SHIFT];
    assign bj_inc  = bj_reg + 1'b1;

    // Lowest non-empty list at or above the target order.
    always_comb begin
        found     = 1'b0;
        found_ord = '0;
        for (int o = TOP_ORDER; o >= 0; o--) begin
            if (ORD_W'(o) >= target && head_reg[o] != NIL) begin
                found     = 1'b1;
                found_ord = ORD_W'(o);
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next      = state_reg;
        call_ret_next   = call_ret_reg;
        patch_ret_next  = patch_ret_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        base_next       = base_reg;
        fcnt_next       = fcnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        idx_next        = idx_reg;
        bud_next        = bud_reg;
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        node_next       = node_reg;
        lst_next        = lst_reg;
        pl_next         = pl_reg;
        nl_next         = nl_reg;
        patch_addr_next = patch_addr_reg;
        patch_nxt_next  = patch_nxt_reg;
        patch_val_next  = patch_val_reg;
        wide_next       = wide_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rp_next         = rp_reg;
        bi_next         = bi_reg;
        bj_next         = bj_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;

        page_we    = 1'b0;
        page_waddr = '0;
        page_wdata = '0;
        page_raddr = '0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                CFG_BASE_ADDRESS: base_next = cfg_data;
                CFG_FRAME_COUNT:  fcnt_next = cfg_data[FC_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_CLR: begin
                page_we    = 1'b1;
                page_waddr = clr_reg;
                page_wdata = '{reserved: 1'b0, order: ORDER_NONE};
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == PG_W'(MAX_PAGES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data;
                    res_next = '{status: ST_DONE, block_address: '0, block_order: '0};
                    case (s_data.command)
                        CMD_ALLOC:   state_next = S_ALC;
                        CMD_FREE:    state_next = S_FREE_A;
                        CMD_RESERVE: state_next = S_RSV_A;
                        default: begin
                            bi_next    = '0;
                            state_next = S_BLD_START;
                        end
                    endcase
                end
            end

            // Allocate.
            S_ALC: begin
                if (target > ORDER_TOP) begin
                    res_next.status = ST_TOO_LARGE;
                    state_next      = S_FIN;
                end else if (!found) begin
                    res_next.status = ST_NO_BLOCK;
                    state_next      = S_FIN;
                end else begin
                    idx_next      = head_reg[found_ord[LIST_W-1:0]][PG_W-1:0];
                    node_next     = head_reg[found_ord[LIST_W-1:0]];
                    lst_next      = found_ord[LIST_W-1:0];
                    cur_next      = found_ord;
                    tgt_next      = target;
                    call_ret_next = S_SPLIT;
                    state_next    = S_UNL_RD;
                end
            end
            S_SPLIT: begin
                if (cur_reg > tgt_reg) begin
                    cur_next = cur_dec;
                    if (bsum < NIL) begin
                        bud_next   = bsum[PG_W-1:0];
                        page_raddr = bsum[PG_W-1:0];
                        state_next = S_SPL_WR;
                    end
                end else begin
                    page_we    = 1'b1;
                    page_waddr = idx_reg;
                    page_wdata = '{reserved: 1'b1, order: tgt_reg};
                    res_next.block_address = base_reg
                        + (ADDR_W'(idx_reg) << PAGE_SHIFT);
                    res_next.block_order   = tgt_reg;
                    state_next = S_FIN;
                end
            end
            S_SPL_WR: begin
                // The split half keeps its reserved bit; only the order changes.
                page_we       = 1'b1;
                page_waddr    = bud_reg;
                page_wdata    = '{reserved: page_q.reserved, order: cur_reg};
                node_next     = {1'b0, bud_reg};
                lst_next      = cur_reg[LIST_W-1:0];
                call_ret_next = S_SPLIT;
                state_next    = S_PUSH_H;
            end

            // Free.
            S_FREE_A: begin
                if (cmd_reg.address == '0 || cmd_reg.address < base_reg) begin
                    res_next.status = ST_IGNORED;
                    state_next      = S_FIN;
                end else begin
                    wide_next  = {1'b0, cmd_reg.address - base_reg};
                    state_next = S_FREE_B;
                end
            end
            S_FREE_B: begin
                if (wide_reg[ADDR_W:PAGE_SHIFT] >= (PGN_W+1)'(fc_eff)) begin
                    res_next.status = ST_IGNORED;
                    state_next      = S_FIN;
                end else begin
                    idx_next   = wide_reg[PAGE_SHIFT +: PG_W];
                    page_raddr = wide_reg[PAGE_SHIFT +: PG_W];
                    state_next = S_FREE_ORD;
                end
            end
            S_FREE_ORD: begin
                if (page_q.order > ORDER_TOP) begin
                    res_next.status = ST_IGNORED;
                    state_next      = S_FIN;
                end else begin
                    page_we    = 1'b1;
                    page_waddr = idx_reg;
                    page_wdata = '{reserved: 1'b0, order: page_q.order};
                    cur_next   = page_q.order;
                    state_next = S_MRG_TEST;
                end
            end
            S_MRG_TEST: begin
                if (cur_reg < ORDER_TOP && {1'b0, bx} < fc_link) begin
                    bud_next   = bx;
                    page_raddr = bx;
                    state_next = S_MRG_CHK;
                end else begin
                    state_next = S_FREE_PUSH;
                end
            end
            S_MRG_CHK: begin
                if (page_q.reserved || page_q.order != cur_reg) begin
                    state_next = S_FREE_PUSH;
                end else begin
                    node_next     = {1'b0, bud_reg};
                    lst_next      = cur_reg[LIST_W-1:0];
                    call_ret_next = S_MRG_UPD;
                    state_next    = S_UNL_RD;
                end
            end
            S_MRG_UPD: begin
                // Both halves are unreserved, so the merged head is too.
                page_we    = 1'b1;
                page_waddr = (bud_reg < idx_reg) ? bud_reg : idx_reg;
                page_wdata = '{reserved: 1'b0, order: cur_reg + 1'b1};
                idx_next   = (bud_reg < idx_reg) ? bud_reg : idx_reg;
                cur_next   = cur_reg + 1'b1;
                state_next = S_MRG_TEST;
            end
            S_FREE_PUSH: begin
                node_next            = {1'b0, idx_reg};
                lst_next             = cur_reg[LIST_W-1:0];
                res_next.block_order = cur_reg;
                call_ret_next        = S_FIN;
                state_next           = S_PUSH_H;
            end

            // Reserve.
            S_RSV_A: begin
                if (cmd_reg.size_bytes == '0 || fc_eff == '0) begin
                    state_next = S_FIN;
                end else begin
                    wide_next  = {1'b0, cmd_reg.address} + (ADDR_W+1)'(cmd_reg.size_bytes)
                                 - 1'b1;
                    lo_next    = (cmd_reg.address < base_reg) ? '0
                                 : PGN_W'((cmd_reg.address - base_reg) >> PAGE_SHIFT);
                    state_next = S_RSV_B;
                end
            end
            S_RSV_B: begin
                if (wide_reg < {1'b0, base_reg}) begin
                    state_next = S_FIN;
                end else begin
                    if (hi_pg >= (PGN_W+1)'(fc_eff)) begin
                        hi_next = PG_W'(fc_eff - 1'b1);
                        if (lo_reg > PGN_W'(fc_eff - 1'b1)) state_next = S_FIN;
                        else state_next = S_RSV_RD;
                    end else begin
                        hi_next = hi_pg[PG_W-1:0];
                        if ({1'b0, lo_reg} > hi_pg) state_next = S_FIN;
                        else state_next = S_RSV_RD;
                    end
                    rp_next = lo_reg[PG_W-1:0];
                end
            end
            S_RSV_RD: begin
                page_raddr = rp_reg;
                state_next = S_RSV_WR;
            end
            S_RSV_WR: begin
                page_we    = 1'b1;
                page_waddr = rp_reg;
                page_wdata = '{reserved: 1'b1, order: page_q.order};
                rp_next    = rp_reg + 1'b1;
                state_next = (rp_reg == hi_reg) ? S_FIN : S_RSV_RD;
            end

            // Build.
            S_BLD_START: begin
                if (bi_reg < fc_link) begin
                    bj_next    = bi_reg;
                    state_next = S_BLD_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_BLD_RD: begin
                page_raddr = bj_reg[PG_W-1:0];
                state_next = S_BLD_CHK;
            end
            S_BLD_CHK: begin
                if (page_q.reserved) begin
                    state_next = S_BLD_NEXT;
                end else if (bj_inc >= fc_link || (bj_inc - bi_reg) == GRP) begin
                    state_next = S_BLD_PUSH;
                end else begin
                    bj_next    = bj_inc;
                    state_next = S_BLD_RD;
                end
            end
            S_BLD_PUSH: begin
                page_we       = 1'b1;
                page_waddr    = bi_reg[PG_W-1:0];
                page_wdata    = '{reserved: 1'b0, order: ORDER_TOP};
                node_next     = bi_reg;
                lst_next      = LIST_W'(TOP_ORDER);
                call_ret_next = S_BLD_NEXT;
                state_next    = S_PUSH_T;
            end
            S_BLD_NEXT: begin
                bi_next    = bi_reg + GRP;
                state_next = S_BLD_START;
            end

            // List unlink of node_reg from list lst_reg, then back to call_ret_reg.
            S_UNL_RD: begin
                link_raddr = node_reg[PG_W-1:0];
                state_next = S_UNL_DAT;
            end
            S_UNL_DAT: begin
                pl_next = link_q.prev;
                nl_next = link_q.next;
                if (link_q.prev < NIL) begin
                    patch_addr_next = link_q.prev;
                    patch_nxt_next  = 1'b1;
                    patch_val_next  = link_q.next;
                    patch_ret_next  = S_UNL_N;
                    state_next      = S_PATCH_RD;
                end else begin
                    head_next[lst_reg] = link_q.next;
                    state_next         = S_UNL_N;
                end
            end
            S_UNL_N: begin
                if (nl_reg < NIL) begin
                    patch_addr_next = nl_reg;
                    patch_nxt_next  = 1'b0;
                    patch_val_next  = pl_reg;
                    patch_ret_next  = call_ret_reg;
                    state_next      = S_PATCH_RD;
                end else begin
                    tail_next[lst_reg] = pl_reg;
                    state_next         = call_ret_reg;
                end
            end

            // Push node_reg at the head or tail of list lst_reg.
            S_PUSH_H: begin
                link_we            = 1'b1;
                link_waddr         = node_reg[PG_W-1:0];
                link_wdata         = '{next: head_reg[lst_reg], prev: NIL};
                head_next[lst_reg] = node_reg;
                if (head_reg[lst_reg] < NIL) begin
                    patch_addr_next = head_reg[lst_reg];
                    patch_nxt_next  = 1'b0;
                    patch_val_next  = node_reg;
                    patch_ret_next  = call_ret_reg;
                    state_next      = S_PATCH_RD;
                end else begin
                    tail_next[lst_reg] = node_reg;
                    state_next         = call_ret_reg;
                end
            end
            S_PUSH_T: begin
                link_we            = 1'b1;
                link_waddr         = node_reg[PG_W-1:0];
                link_wdata         = '{next: NIL, prev: tail_reg[lst_reg]};
                tail_next[lst_reg] = node_reg;
                if (tail_reg[lst_reg] < NIL) begin
                    patch_addr_next = tail_reg[lst_reg];
                    patch_nxt_next  = 1'b1;
                    patch_val_next  = node_reg;
                    patch_ret_next  = call_ret_reg;
                    state_next      = S_PATCH_RD;
                end else begin
                    head_next[lst_reg] = node_reg;
                    state_next         = call_ret_reg;
                end
            end

            // Read-modify-write of one link field. Accesses are strictly serialized,
            // so a read never overlaps a pending write to the same entry.
            S_PATCH_RD: begin
                link_raddr = patch_addr_reg[PG_W-1:0];
                state_next = S_PATCH_WR;
            end
            S_PATCH_WR: begin
                link_we    = 1'b1;
                link_waddr = patch_addr_reg[PG_W-1:0];
                link_wdata = patch_nxt_reg ? '{next: patch_val_reg, prev: link_q.prev}
                                           : '{next: link_q.next, prev: patch_val_reg};
                state_next = patch_ret_reg;
            end

            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            call_ret_reg   <= S_IDLE;
            patch_ret_reg  <= S_IDLE;
            clr_reg        <= '0;
            base_reg       <= '0;
            fcnt_reg       <= FC_W'(MAX_PAGES);
            m_valid_reg    <= 1'b0;
            for (int o = 0; o < LISTS; o++) begin
                head_reg[o] <= NIL;
                tail_reg[o] <= NIL;
            end
        end else begin
            state_reg      <= state_next;
            call_ret_reg   <= call_ret_next;
            patch_ret_reg  <= patch_ret_next;
            clr_reg        <= clr_next;
            base_reg       <= base_next;
            fcnt_reg       <= fcnt_next;
            m_valid_reg    <= m_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        bud_reg        <= bud_next;
        cur_reg        <= cur_next;
        tgt_reg        <= tgt_next;
        node_reg       <= node_next;
        lst_reg        <= lst_next;
        pl_reg         <= pl_next;
        nl_reg         <= nl_next;
        patch_addr_reg <= patch_addr_next;
        patch_nxt_reg  <= patch_nxt_next;
        patch_val_reg  <= patch_val_next;
        wide_reg       <= wide_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        rp_reg         <= rp_next;
        bi_reg         <= bi_next;
        bj_reg         <= bj_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end
endmodule
